[hw/rtl/lss_pkg.sv]
// Package of shared constants and default parameter values for the LED script sequencer.
package lss_pkg;

   localparam int PROG_BYTES_DEF = 256;
   localparam int MAX_STEPS_DEF  = 8;
   localparam int RESULT_LIMIT   = 25;

   // Command codes of the request channel.
   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_WRITE   = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   // Instruction opcodes (high nibble of the first instruction byte).
   localparam logic [3:0] OP_FADE  = 4'd1;
   localparam logic [3:0] OP_FADE3 = 4'd2;
   localparam logic [3:0] OP_JUMP  = 4'd3;
   localparam logic [3:0] OP_SET   = 4'd4;
   localparam logic [3:0] OP_SLEEP = 4'd5;
   localparam logic [3:0] OP_STOP  = 4'd8;

   // Result kinds.
   localparam logic [1:0] KIND_FADE   = 2'd0;
   localparam logic [1:0] KIND_SET    = 2'd1;
   localparam logic [1:0] KIND_TARGET = 2'd2;
   localparam logic [1:0] KIND_END    = 2'd3;

   // Script status reported in the end result.
   localparam logic [1:0] STATUS_RUN   = 2'd0;
   localparam logic [1:0] STATUS_SLEEP = 2'd1;
   localparam logic [1:0] STATUS_STOP  = 2'd2;

endpackage

[hw/rtl/led_script_sequencer_top.sv]
// Top level of the LED script sequencer: script interpreter around the program RAM.
//
//  channel   ports                                   transfer when
//  request   start, busy, req_cmd/address/data       start high and busy low
//  result    rsp_valid, rsp_kind ... rsp_last        rsp_valid high (one cycle)
//  config    csr_valid, csr_ready, csr_data          csr_valid and csr_ready high
//
// Write and restart requests keep busy high for one cycle; the end result follows.
// A tick runs each instruction through a check, four byte reads through the single
// RAM read port, a wait for read data and an execute step, plus emit steps for
// channels 1 and 2 of a three-target fade, then ends with the end result; a tick cut
// by the step cap or the result budget goes from a failing check to the end result.
// Reset is synchronous and clears the counters and flags; the program RAM is not cleared.
// Results cannot be stalled: each one is presented for exactly one cycle.
module led_script_sequencer_top
   import lss_pkg::*;
#(
   parameter int PROG_BYTES = PROG_BYTES_DEF,
   parameter int MAX_STEPS  = MAX_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_address,
   input  logic [7:0]  req_data,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_channel,
   output logic [7:0]  rsp_value,
   output logic [15:0] rsp_speed,
   output logic [1:0]  rsp_status,
   output logic        rsp_truncated,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam int AW = $clog2(PROG_BYTES);
   localparam int SW = $clog2(MAX_STEPS + 1);
   localparam int NW = $clog2(RESULT_LIMIT + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_FETCH,
      S_WAIT,
      S_EXEC,
      S_EMIT,
      S_END
   } state_type;

   state_type        state_ff, state_in;
   logic [AW-1:0]    pc_ff, pc_in;
   logic [AW-1:0]    saved_ff, saved_in;
   logic [15:0]      sleep_cnt_ff, sleep_cnt_in;
   logic             sleeping_ff, sleeping_in;
   logic             stopped_ff, stopped_in;
   logic [7:0]       start_addr_ff, start_addr_in;
   logic [SW-1:0]    steps_ff, steps_in;
   logic [NW-1:0]    nres_ff, nres_in;
   logic             trunc_ff, trunc_in;
   logic [1:0]       fetch_idx_ff, fetch_idx_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [1:0]       rd_idx_ff, rd_idx_in;
   logic [7:0]       byte_ff [4];
   logic [7:0]       byte_in [4];
   logic [1:0]       emit_ch_ff, emit_ch_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_kind_ff, rsp_kind_in;
   logic [7:0]       rsp_channel_ff, rsp_channel_in;
   logic [7:0]       rsp_value_ff, rsp_value_in;
   logic [15:0]      rsp_speed_ff, rsp_speed_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_trunc_ff, rsp_trunc_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             ram_we;
   logic [AW-1:0]    ram_wa;
   logic [7:0]       ram_rd;
   logic [AW:0]      pc_next;
   logic [AW-1:0]    pc_inc;
   logic [15:0]      sleep_dec;
   logic [3:0]       op_code;
   logic [3:0]       op_flags;

   // Reduces an 8-bit address modulo PROG_BYTES by four conditional subtractions
   // of PROG_BYTES times 8, 4, 2 and 1 (PROG_BYTES is at least 16).
   function automatic logic [AW-1:0] wrap_addr(input logic [7:0] a);
      logic [20:0] v;
      v = 21'(a);
      for (int k = 3; k >= 0; k--) begin
         if (v >= (21'(PROG_BYTES) << k)) begin
            v = v - (21'(PROG_BYTES) << k);
         end
      end
      return v[AW-1:0];
   endfunction

   lss_ram #(
      .WIDTH (8),
      .DEPTH (PROG_BYTES)
   ) u_prog_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (req_data),
      .rd_addr (pc_ff),
      .rd_data (ram_rd)
   );

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign ram_wa    = wrap_addr(req_address);
   assign pc_next   = {1'b0, pc_ff} + (AW + 1)'(1);
   assign pc_inc    = (pc_next == (AW + 1)'(PROG_BYTES)) ? '0 : pc_next[AW-1:0];
   assign sleep_dec = sleep_cnt_ff - 16'd1;
   assign op_code   = byte_ff[0][7:4];
   assign op_flags  = byte_ff[0][3:0];

   always_comb begin
      state_in       = state_ff;
      pc_in          = pc_ff;
      saved_in       = saved_ff;
      sleep_cnt_in   = sleep_cnt_ff;
      sleeping_in    = sleeping_ff;
      stopped_in     = stopped_ff;
      start_addr_in  = start_addr_ff;
      steps_in       = steps_ff;
      nres_in        = nres_ff;
      trunc_in       = trunc_ff;
      fetch_idx_in   = fetch_idx_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = rd_idx_ff;
      byte_in        = byte_ff;
      emit_ch_in     = emit_ch_ff;
      rsp_valid_in   = 1'b0;
      rsp_kind_in    = KIND_END;
      rsp_channel_in = 8'd0;
      rsp_value_in   = 8'd0;
      rsp_speed_in   = 16'd0;
      rsp_status_in  = STATUS_RUN;
      rsp_trunc_in   = 1'b0;
      rsp_last_in    = 1'b0;
      ram_we         = 1'b0;

      if (csr_valid) begin
         start_addr_in = csr_data;
      end
      // Read data of the previous cycle lands in its instruction byte slot.
      if (rd_vld_ff) begin
         byte_in[rd_idx_ff] = ram_rd;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               steps_in = '0;
               nres_in  = '0;
               trunc_in = 1'b0;
               state_in = S_END;
               unique case (req_cmd)
                  CMD_WRITE: begin
                     ram_we = 1'b1;
                  end
                  CMD_RESTART: begin
                     pc_in        = wrap_addr(start_addr_ff);
                     sleeping_in  = 1'b0;
                     stopped_in   = 1'b0;
                     sleep_cnt_in = 16'd0;
                  end
                  CMD_TICK: begin
                     if (!stopped_ff) begin
                        if (sleeping_ff) begin
                           sleep_cnt_in = sleep_dec;
                           if (sleep_dec == 16'd0) begin
                              sleeping_in = 1'b0;
                              pc_in       = saved_ff;
                           end
                        end else begin
                           state_in = S_CHECK;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CHECK: begin
            if (steps_ff >= SW'(MAX_STEPS) || nres_ff > NW'(RESULT_LIMIT - 4)) begin
               trunc_in = 1'b1;
               state_in = S_END;
            end else begin
               steps_in     = steps_ff + SW'(1);
               fetch_idx_in = 2'd0;
               state_in     = S_FETCH;
            end
         end
         S_FETCH: begin
            rd_vld_in = 1'b1;
            rd_idx_in = fetch_idx_ff;
            pc_in     = pc_inc;
            if (fetch_idx_ff == 2'd3) begin
               state_in = S_WAIT;
            end else begin
               fetch_idx_in = fetch_idx_ff + 2'd1;
            end
         end
         S_WAIT: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            unique case (op_code)
               OP_FADE: begin
                  rsp_valid_in   = 1'b1;
                  rsp_kind_in    = KIND_FADE;
                  rsp_channel_in = {4'd0, op_flags};
                  rsp_value_in   = byte_ff[1];
                  rsp_speed_in   = {byte_ff[3], byte_ff[2]};
                  nres_in        = nres_ff + NW'(1);
                  state_in       = S_CHECK;
               end
               OP_FADE3: begin
                  rsp_valid_in   = 1'b1;
                  rsp_kind_in    = KIND_TARGET;
                  rsp_channel_in = 8'd0;
                  rsp_value_in   = byte_ff[1];
                  nres_in        = nres_ff + NW'(1);
                  emit_ch_in     = 2'd1;
                  state_in       = S_EMIT;
               end
               OP_JUMP: begin
                  state_in = S_CHECK;
               end
               OP_SET: begin
                  rsp_valid_in   = 1'b1;
                  rsp_kind_in    = KIND_SET;
                  rsp_channel_in = byte_ff[1];
                  rsp_value_in   = byte_ff[2];
                  nres_in        = nres_ff + NW'(1);
                  state_in       = S_CHECK;
               end
               OP_SLEEP: begin
                  saved_in     = pc_ff;
                  sleep_cnt_in = {byte_ff[2], byte_ff[1]};
                  sleeping_in  = 1'b1;
                  state_in     = S_END;
               end
               OP_STOP: begin
                  stopped_in = 1'b1;
                  state_in   = S_END;
               end
               default: begin
                  state_in = S_END;
               end
            endcase
         end
         S_EMIT: begin
            rsp_valid_in   = 1'b1;
            rsp_kind_in    = KIND_TARGET;
            rsp_channel_in = {6'd0, emit_ch_ff};
            rsp_value_in   = (emit_ch_ff == 2'd1) ? byte_ff[2] : byte_ff[3];
            nres_in        = nres_ff + NW'(1);
            if (emit_ch_ff == 2'd2) begin
               state_in = S_CHECK;
            end else begin
               emit_ch_in = 2'd2;
            end
         end
         S_END: begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = KIND_END;
            rsp_status_in = stopped_ff ? STATUS_STOP :
                            (sleeping_ff ? STATUS_SLEEP : STATUS_RUN);
            rsp_trunc_in  = trunc_ff;
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pc_ff         <= '0;
         saved_ff      <= '0;
         sleep_cnt_ff  <= 16'd0;
         sleeping_ff   <= 1'b0;
         stopped_ff    <= 1'b0;
         start_addr_ff <= 8'd0;
         steps_ff      <= '0;
         nres_ff       <= '0;
         trunc_ff      <= 1'b0;
         fetch_idx_ff  <= 2'd0;
         rd_vld_ff     <= 1'b0;
         rd_idx_ff     <= 2'd0;
         emit_ch_ff    <= 2'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pc_ff         <= pc_in;
         saved_ff      <= saved_in;
         sleep_cnt_ff  <= sleep_cnt_in;
         sleeping_ff   <= sleeping_in;
         stopped_ff    <= stopped_in;
         start_addr_ff <= start_addr_in;
         steps_ff      <= steps_in;
         nres_ff       <= nres_in;
         trunc_ff      <= trunc_in;
         fetch_idx_ff  <= fetch_idx_in;
         rd_vld_ff     <= rd_vld_in;
         rd_idx_ff     <= rd_idx_in;
         emit_ch_ff    <= emit_ch_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      byte_ff        <= byte_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_channel_ff <= rsp_channel_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_speed_ff   <= rsp_speed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_trunc_ff   <= rsp_trunc_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_channel   = rsp_channel_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_speed     = rsp_speed_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_truncated = rsp_trunc_ff;
   assign rsp_last      = rsp_last_ff;

   // An accepted request always leaves the idle state.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request transfer did not start processing");

   // The closing result of a request is an end result and frees the block.
   a_last_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_kind == KIND_END && !busy)
      else $error("closing result is malformed or block still busy");

   // The step counter never passes its cap.
   a_step_cap: assert property (@(posedge clock) disable iff (reset)
      steps_ff <= SW'(MAX_STEPS))
      else $error("step counter exceeded cap");

   // A stopped script cannot also be sleeping.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(stopped_ff && sleeping_ff))
      else $error("script both stopped and sleeping");

   // Instruction bytes are read only while a tick is executing.
   a_fetch_in_tick: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> state_ff == S_FETCH || state_ff == S_WAIT)
      else $error("program read outside the fetch sequence");

endmodule

[hw/rtl/lss_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module lss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[bench/tb.sv]
// Self-checking testbench for the LED script sequencer: directed script table, then random scripts.
module tb;
   import lss_pkg::*;

   localparam int         MAX_STEPS     = MAX_STEPS_DEF;
   localparam int         SCRIPT_WINDOW = 4 * MAX_STEPS;
   localparam int         RANDOM_ITEMS  = 200;
   localparam int         DRAIN_CYCLES  = 120;
   localparam int         LIMIT_CYCLES  = 600000;
   localparam logic [1:0] CMD_UNUSED    = 2'd3;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [1:0]   cmd;
      logic [7:0]   address;
      logic [7:0]   data;
      bit           typed;
      logic [1:0]   status;
      logic         truncated;
   } script_row_type;

   typedef struct {
      logic [1:0]  kind;
      logic [7:0]  channel;
      logic [7:0]  value;
      logic [15:0] speed;
      logic [1:0]  status;
      logic        truncated;
      logic        last;
   } pwm_update_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_cmd;
   logic [7:0]  req_address;
   logic [7:0]  req_data;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_channel;
   logic [7:0]  rsp_value;
   logic [15:0] rsp_speed;
   logic [1:0]  rsp_status;
   logic        rsp_truncated;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_data;

   // Shadow of the interpreter state.
   logic [7:0]  script_mem [256];
   bit          written [256];
   logic [7:0]  pc;
   logic [7:0]  saved_pc;
   logic [15:0] sleep_ctr;
   bit          is_sleeping;
   bit          is_stopped;
   logic [7:0]  start_addr;

   pwm_update_type updates_due [$];
   script_row_type script_rows [$];

   int errors        = 0;
   int cycles        = 0;
   int items_sent    = 0;
   int n_updates     = 0;
   int n_acks        = 0;
   int n_trunc       = 0;
   int sleep_ticks   = 0;
   int n_csr         = 0;
   bit fill_random   = 1'b0;
   bit quiet_phase   = 1'b0;

   led_script_sequencer_top u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_address   (req_address),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_kind      (rsp_kind),
      .rsp_channel   (rsp_channel),
      .rsp_value     (rsp_value),
      .rsp_speed     (rsp_speed),
      .rsp_status    (rsp_status),
      .rsp_truncated (rsp_truncated),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   function automatic script_row_type mk_row(input row_kind_type k, input logic [1:0] c,
                                             input logic [7:0] a, input logic [7:0] d,
                                             input bit t, input logic [1:0] s,
                                             input logic tr);
      script_row_type row;
      row.kind      = k;
      row.cmd       = c;
      row.address   = a;
      row.data      = d;
      row.typed     = t;
      row.status    = s;
      row.truncated = tr;
      return row;
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet_phase)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void queue_update(input logic [1:0] kind, input logic [7:0] chan,
                                        input logic [7:0] val, input logic [15:0] spd,
                                        input logic [1:0] st, input logic tr,
                                        input logic fin);
      pwm_update_type u;
      u.kind      = kind;
      u.channel   = chan;
      u.value     = val;
      u.speed     = spd;
      u.status    = st;
      u.truncated = tr;
      u.last      = fin;
      updates_due.push_back(u);
   endfunction

   function automatic logic [7:0] next_script_byte();
      logic [7:0] b;
      b  = script_mem[pc];
      pc = pc + 8'd1;
      return b;
   endfunction

   // Applies one accepted request to the shadow state and queues the results it causes.
   // A typed row supplies the status and truncated flag of the end result by hand.
   task automatic interpret_item(input logic [1:0] cmd, input logic [7:0] addr,
                                 input logic [7:0] data, input bit typed,
                                 input logic [1:0] typed_st, input logic typed_tr);
      int         steps;
      int         first;
      bit         halt;
      bit         cut;
      logic [7:0] op;
      logic [7:0] p1;
      logic [7:0] p2;
      logic [7:0] p3;
      logic [1:0] st;
      steps = 0;
      first = updates_due.size();
      halt  = 1'b0;
      cut   = 1'b0;
      if (cmd == CMD_WRITE) begin
         script_mem[addr] = data;
         written[addr]    = 1'b1;
      end else if (cmd == CMD_RESTART) begin
         pc          = start_addr;
         is_sleeping = 1'b0;
         is_stopped  = 1'b0;
         sleep_ctr   = 16'd0;
      end else if (cmd == CMD_TICK && !is_stopped) begin
         if (is_sleeping) begin
            sleep_ticks++;
            sleep_ctr = sleep_ctr - 16'd1;
            if (sleep_ctr == 16'd0) begin
               is_sleeping = 1'b0;
               pc          = saved_pc;
            end
         end else begin
            while (!halt && !cut) begin
               // The tick is cut short at the step cap or when a three-target fade
               // might no longer fit in the result budget.
               if (steps >= MAX_STEPS || RESULT_LIMIT - (updates_due.size() - first) < 4) begin
                  cut = 1'b1;
               end else begin
                  steps++;
                  op = next_script_byte();
                  p1 = next_script_byte();
                  p2 = next_script_byte();
                  p3 = next_script_byte();
                  case (op[7:4])
                     OP_FADE: begin
                        queue_update(KIND_FADE, {4'd0, op[3:0]}, p1, {p3, p2}, '0, 1'b0, 1'b0);
                     end
                     OP_FADE3: begin
                        queue_update(KIND_TARGET, 8'd0, p1, '0, '0, 1'b0, 1'b0);
                        queue_update(KIND_TARGET, 8'd1, p2, '0, '0, 1'b0, 1'b0);
                        queue_update(KIND_TARGET, 8'd2, p3, '0, '0, 1'b0, 1'b0);
                     end
                     OP_JUMP: begin
                     end
                     OP_SET: begin
                        queue_update(KIND_SET, p1, p2, '0, '0, 1'b0, 1'b0);
                     end
                     OP_SLEEP: begin
                        saved_pc    = pc;
                        sleep_ctr   = {p2, p1};
                        is_sleeping = 1'b1;
                        halt        = 1'b1;
                     end
                     OP_STOP: begin
                        is_stopped = 1'b1;
                        halt       = 1'b1;
                     end
                     default: begin
                        halt = 1'b1;
                     end
                  endcase
               end
            end
         end
      end
      if (is_stopped)
         st = STATUS_STOP;
      else if (is_sleeping)
         st = STATUS_SLEEP;
      else
         st = STATUS_RUN;
      if (typed)
         queue_update(KIND_END, '0, '0, '0, typed_st, typed_tr, 1'b1);
      else
         queue_update(KIND_END, '0, '0, '0, st, cut, 1'b1);
   endtask

   // Moves one request across the start/busy handshake and predicts it on the transfer.
   task automatic transfer_item(input logic [1:0] cmd, input logic [7:0] addr,
                                input logic [7:0] data, input bit typed,
                                input logic [1:0] typed_st, input logic typed_tr);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_cmd     <= cmd;
      req_address <= addr;
      req_data    <= data;
      @(posedge clock);
      while (busy) @(posedge clock);
      interpret_item(cmd, addr, data, typed, typed_st, typed_tr);
      if (cmd != CMD_UNUSED)
         items_sent++;
   endtask

   // A running tick may read up to SCRIPT_WINDOW bytes from the counter on, so any of
   // them never written so far gets written before the tick goes out.
   task automatic fill_script_window();
      logic [7:0] a;
      int         k;
      if (!is_stopped && !is_sleeping) begin
         for (k = 0; k < SCRIPT_WINDOW; k++) begin
            a = pc + 8'(k);
            if (!written[a])
               transfer_item(CMD_WRITE, a, fill_random ? 8'($urandom_range(0, 255)) : 8'h00,
                             1'b0, '0, 1'b0);
         end
      end
   endtask

   task automatic send(input logic [1:0] cmd, input logic [7:0] addr, input logic [7:0] data,
                       input bit typed, input logic [1:0] typed_st, input logic typed_tr);
      if (cmd == CMD_TICK)
         fill_script_window();
      transfer_item(cmd, addr, data, typed, typed_st, typed_tr);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (updates_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_start_address(input logic [7:0] v);
      int gap;
      drain();
      gap = pick_gap();
      repeat (gap) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      start_addr = v;
      csr_valid <= 1'b0;
      n_csr++;
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      pwm_update_type want;
      if (!reset && rsp_valid) begin
         if (updates_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual kind %0d channel %0d value %0d",
                     $time, rsp_kind, rsp_channel, rsp_value);
         end else begin
            want = updates_due.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("channel", want.channel, rsp_channel);
            check_field("value", want.value, rsp_value);
            check_field("speed", want.speed, rsp_speed);
            check_field("status", want.status, rsp_status);
            check_field("truncated", want.truncated, rsp_truncated);
            check_field("last", want.last, rsp_last);
            if (want.last) begin
               n_acks++;
               if (want.truncated)
                  n_trunc++;
            end else begin
               n_updates++;
            end
         end
      end
   end

   initial begin : stimulus
      int             i;
      int             j;
      int             r;
      int             n_instr;
      int             n_ticks;
      int             random_first;
      logic [7:0]     base;
      logic [3:0]     code;
      logic [7:0]     p1;
      logic [7:0]     p2;
      script_row_type row;

      reset       = 1'b1;
      start       = 1'b0;
      req_cmd     = CMD_TICK;
      req_address = 8'd0;
      req_data    = 8'd0;
      csr_valid   = 1'b0;
      csr_data    = 8'd0;
      pc          = 8'd0;
      saved_pc    = 8'd0;
      sleep_ctr   = 16'd0;
      is_sleeping = 1'b0;
      is_stopped  = 1'b0;
      start_addr  = 8'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // First script at address 0: fade, three-target fade, set, jump, sleep of one tick, an
      // unassigned opcode that ends the tick, then stop. Bytes left out of the table are filled with zeros.
      script_rows.push_back(mk_row(ROW_ITEM, CMD_UNUSED,  8'hff, 8'hff, 1, STATUS_RUN, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_WRITE,   8'h00, 8'h1f, 1, STATUS_RUN, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_WRITE,   8'h01, 8'hff, 0, '0, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_WRITE,   8'h02, 8'h00, 0, '0, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_WRITE,   8'h03, 8'hff, 0, '0, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_WRITE,   8'h04, 8'h20, 0, '0, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_WRITE,   8'h06, 8'h80, 0, '0, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_WRITE,   8'h07, 8'hff, 0, '0, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_WRITE,   8'h08, 8'h40, 0, '0, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_WRITE,   8'h09, 8'hff, 0, '0, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_WRITE,   8'h0c, 8'h30, 0, '0, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_WRITE,   8'h10, 8'h50, 0, '0, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_WRITE,   8'h11, 8'h01, 0, '0, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_TICK,    8'h00, 8'h00, 1, STATUS_SLEEP, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_TICK,    8'h00, 8'h00, 1, STATUS_RUN, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_TICK,    8'h00, 8'h00, 0, '0, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_WRITE,   8'h18, 8'h80, 0, '0, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_TICK,    8'h00, 8'h00, 1, STATUS_STOP, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_TICK,    8'h00, 8'h00, 1, STATUS_STOP, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_RESTART, 8'h00, 8'h00, 1, STATUS_RUN, 0));
      // Four jumps at the top of the store wrap into the first script, so eight steps
      // run without a break and the tick is cut by the step cap.
      script_rows.push_back(mk_row(ROW_CSR,  CMD_TICK,    8'h00, 8'hf0, 0, '0, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_WRITE,   8'hf0, 8'h30, 0, '0, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_WRITE,   8'hf4, 8'h30, 0, '0, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_WRITE,   8'hf8, 8'h30, 0, '0, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_WRITE,   8'hfc, 8'h30, 0, '0, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_RESTART, 8'h00, 8'h00, 0, '0, 0));
      script_rows.push_back(mk_row(ROW_ITEM, CMD_TICK,    8'h00, 8'h00, 1, STATUS_RUN, 1));

      for (i = 0; i < script_rows.size(); i++) begin
         row = script_rows[i];
         if (row.kind == ROW_CSR)
            set_start_address(row.data);
         else
            send(row.cmd, row.address, row.data, row.typed, row.status, row.truncated);
      end

      // Random scripts: mostly a program written at the start address, a restart and a
      // run of ticks, with stray writes, restarts, unused commands and drains mixed in.
      fill_random  = 1'b1;
      random_first = items_sent;
      while (items_sent - random_first < RANDOM_ITEMS) begin
         quiet_phase = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 2) == 0) begin
            r = $urandom_range(0, 3);
            if (r == 0)
               set_start_address(8'h00);
            else if (r == 1)
               set_start_address(8'hff);
            else if (r == 2)
               set_start_address(8'($urandom_range(0, 255)));
            else
               set_start_address(8'($urandom_range(0, 63) * 4));
         end
         base = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : start_addr;
         n_instr = $urandom_range(1, 6);
         for (i = 0; i < n_instr; i++) begin
            r = $urandom_range(0, 99);
            if (r < 18)
               code = OP_FADE;
            else if (r < 36)
               code = OP_FADE3;
            else if (r < 52)
               code = OP_JUMP;
            else if (r < 68)
               code = OP_SET;
            else if (r < 78)
               code = OP_SLEEP;
            else if (r < 83)
               code = OP_STOP;
            else begin
               do
                  code = 4'($urandom_range(0, 15));
               while ((code >= OP_FADE && code <= OP_SLEEP) || code == OP_STOP);
            end
            p1 = 8'($urandom_range(0, 255));
            p2 = 8'($urandom_range(0, 255));
            if (code == OP_SLEEP) begin
               // Short sleeps keep the script moving; a zero count sleeps the longest.
               r = $urandom_range(0, 99);
               if (r < 70) begin
                  p1 = 8'($urandom_range(1, 3));
                  p2 = 8'h00;
               end else if (r < 85) begin
                  p1 = 8'h00;
                  p2 = 8'h00;
               end
            end
            send(CMD_WRITE, base + 8'(4 * i), {code, 4'($urandom_range(0, 15))}, 0, '0, 0);
            send(CMD_WRITE, base + 8'(4 * i + 1), p1, 0, '0, 0);
            send(CMD_WRITE, base + 8'(4 * i + 2), p2, 0, '0, 0);
            send(CMD_WRITE, base + 8'(4 * i + 3), 8'($urandom_range(0, 255)), 0, '0, 0);
         end
         if ($urandom_range(0, 4) != 0)
            send(CMD_RESTART, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 0, '0, 0);
         n_ticks = $urandom_range(2, 10);
         for (j = 0; j < n_ticks; j++) begin
            r = $urandom_range(0, 99);
            if (r < 8)
               send(CMD_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    0, '0, 0);
            else if (r < 12)
               send(CMD_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    0, '0, 0);
            else if (r < 16)
               send(CMD_RESTART, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    0, '0, 0);
            else if (r < 20)
               drain();
            send(CMD_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 0, '0, 0);
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("tb: %0d requests sent, %0d channel updates and %0d end results checked",
               items_sent, n_updates, n_acks);
      $display("tb: %0d ticks cut by the step cap, %0d sleeping ticks, %0d start address writes",
               n_trunc, sleep_ticks, n_csr);
      if (errors == 0 && updates_due.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/lss_pkg.sv
hw/rtl/lss_ram.sv
hw/rtl/led_script_sequencer_top.sv
bench/tb.sv
